[rtl/gfm_pkg.sv]
// Shared types and constants for the grid field map block.
// Item payloads, mode and status codes, controller states and
// the command and status bundles between controller and datapath.
package gfm_pkg;

  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned OUT_W     = 24;
  localparam int unsigned RAW_W     = 24;
  localparam int unsigned SCALE_W   = 18;
  localparam int unsigned SCALE_SH  = 16;
  localparam int unsigned GRID_W    = 23;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_Z    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE    = 3'd7;

  localparam logic [31:0]        RST_INV   = 32'd1677722;
  localparam logic [GRID_W-1:0]  RST_GRID  = 23'd4210752;
  localparam logic [SCALE_W-1:0] RST_SCALE = 18'd65536;

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  typedef enum logic [1:0] {
    MODE_CLEAR, MODE_LOAD, MODE_FINISH, MODE_QUERY
  } gfm_mode_e;

  typedef enum logic [2:0] {
    STS_OK, STS_NOT_READY, STS_RANGE, STS_OFF_GRID, STS_DUP, STS_INCOMPLETE, STS_ABORTED
  } gfm_status_e;

  typedef enum logic [3:0] {
    ST_SWEEP, ST_IDLE, ST_MUL, ST_RND, ST_CLASS, ST_DECIDE, ST_SEEN_RD, ST_SEEN_CHK,
    ST_NODE_RD, ST_LERP_MUL, ST_LERP_RND, ST_RESULT
  } gfm_state_e;

  typedef enum logic [1:0] {LVL_Z, LVL_Y, LVL_X} gfm_level_e;

  typedef struct packed {
    gfm_mode_e          mode;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [23:0] raw_field_x;
    logic signed [23:0] raw_field_y;
    logic signed [23:0] raw_field_z;
  } gfm_in_t;

  typedef struct packed {
    gfm_status_e        status;
    logic               ready_res;
    logic signed [23:0] field_x;
    logic signed [23:0] field_y;
    logic signed [23:0] field_z;
  } gfm_out_t;

  typedef struct packed {
    logic       coord_mul;
    logic       coord_rnd;
    logic [1:0] axis;
    logic       classify;
    logic       sweep_step;
    logic       seen_rd;
    logic       store_wr;
    logic       rec_clr;
    logic       node_rd;
    logic [2:0] node_idx;
    logic       node_push;
    logic       lerp_mul;
    logic       lerp_rnd;
    gfm_level_e level;
  } gfm_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic load_ok;
    logic query_ok;
    logic seen;
    logic count_full;
  } gfm_sts_t;

endpackage

[rtl/gfm_lane.sv]
// One field component lane: load scaling and the trilinear blend unit.
// Depends on gfm_pkg.
module gfm_lane #(
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned FIELD_BITS = 24
) (
  input  logic                          clk_i,
  input  logic signed [23:0]            raw_i,
  input  logic [17:0]                   scale_i,
  output logic signed [FIELD_BITS-1:0]  store_o,
  input  logic signed [FIELD_BITS-1:0]  node_i,
  input  logic                          node_push_i,
  input  logic                          lerp_mul_i,
  input  logic                          lerp_rnd_i,
  input  gfm_pkg::gfm_level_e           level_i,
  input  logic [FRAC_BITS-1:0]          wz_i,
  input  logic [FRAC_BITS-1:0]          wy_i,
  input  logic [FRAC_BITS-1:0]          wx_i,
  output logic signed [23:0]            res_o
);
  import gfm_pkg::*;

  localparam int unsigned DW = FIELD_BITS + 1;
  localparam int unsigned PW = DW + FRAC_BITS + 1;
  localparam int unsigned LV = FIELD_BITS + FRAC_BITS + 3;
  localparam logic [LV-1:0] HALF_F = LV'(1) << (FRAC_BITS - 1);
  localparam logic signed [39:0] FB_HI = (40'sd1 <<< (FIELD_BITS - 1)) - 40'sd1;
  localparam logic signed [39:0] FB_LO = -FB_HI - 40'sd1;
  localparam logic signed [39:0] O_HI  = 40'sd8388607;
  localparam logic signed [39:0] O_LO  = -40'sd8388608;

  // load path: raw * scale / 2^16, rounded half away from zero, saturated
  logic signed [42:0] ld_prod_q;
  logic [42:0]        ld_mag, ld_sum;
  logic signed [39:0] ld_v;

  always_ff @(posedge clk_i) begin
    ld_prod_q <= raw_i * $signed({1'b0, scale_i});
  end

  assign ld_mag = ld_prod_q[42] ? 43'(-ld_prod_q) : 43'(ld_prod_q);
  assign ld_sum = ld_mag + (43'd1 << (SCALE_SH - 1));
  assign ld_v   = ld_prod_q[42] ? -$signed({13'd0, ld_sum[42:SCALE_SH]})
                                :  $signed({13'd0, ld_sum[42:SCALE_SH]});

  always_comb begin
    if (ld_v > FB_HI)      store_o = FB_HI[FIELD_BITS-1:0];
    else if (ld_v < FB_LO) store_o = FB_LO[FIELD_BITS-1:0];
    else                   store_o = ld_v[FIELD_BITS-1:0];
  end

  // blend lines: eight corners, then four, then two, then one
  logic signed [FIELD_BITS-1:0] vz_q [8];
  logic signed [FIELD_BITS-1:0] vy_q [4];
  logic signed [FIELD_BITS-1:0] vx_q [2];
  logic signed [FIELD_BITS-1:0] fin_q;

  logic signed [FIELD_BITS-1:0] a_sel, b_sel, a_q;
  logic [FRAC_BITS-1:0]         w_sel;
  logic signed [DW-1:0]         diff;
  logic signed [PW-1:0]         prod_q;
  logic signed [LV-1:0]         sum_v;
  logic [LV-1:0]                mag_v, rnd_v;
  logic signed [FIELD_BITS-1:0] blend;

  always_comb begin
    case (level_i)
      LVL_Z: begin
        a_sel = vz_q[0];
        b_sel = vz_q[1];
        w_sel = wz_i;
      end
      LVL_Y: begin
        a_sel = vy_q[0];
        b_sel = vy_q[1];
        w_sel = wy_i;
      end
      default: begin
        a_sel = vx_q[0];
        b_sel = vx_q[1];
        w_sel = wx_i;
      end
    endcase
  end

  // a*(1-w) + b*w rewritten as a + (b-a)*w
  assign diff  = DW'(b_sel) - DW'(a_sel);
  assign sum_v = (LV'(a_q) <<< FRAC_BITS) + LV'(prod_q);
  assign mag_v = sum_v[LV-1] ? LV'(-sum_v) : LV'(sum_v);
  assign rnd_v = (mag_v + HALF_F) >> FRAC_BITS;
  assign blend = sum_v[LV-1] ? FIELD_BITS'(-rnd_v) : FIELD_BITS'(rnd_v);

  always_ff @(posedge clk_i) begin
    if (lerp_mul_i) begin
      prod_q <= diff * $signed({1'b0, w_sel});
      a_q    <= a_sel;
    end
    if (node_push_i) begin
      for (int i = 0; i < 7; i++) vz_q[i] <= vz_q[i+1];
      vz_q[7] <= node_i;
    end else if (lerp_mul_i && level_i == LVL_Z) begin
      for (int i = 0; i < 6; i++) vz_q[i] <= vz_q[i+2];
    end
    if (lerp_rnd_i && level_i == LVL_Z) begin
      for (int i = 0; i < 3; i++) vy_q[i] <= vy_q[i+1];
      vy_q[3] <= blend;
    end else if (lerp_mul_i && level_i == LVL_Y) begin
      vy_q[0] <= vy_q[2];
      vy_q[1] <= vy_q[3];
    end
    if (lerp_rnd_i && level_i == LVL_Y) begin
      vx_q[0] <= vx_q[1];
      vx_q[1] <= blend;
    end
    if (lerp_rnd_i && level_i == LVL_X) begin
      fin_q <= blend;
    end
  end

  logic signed [39:0] fin_ext;
  assign fin_ext = 40'(fin_q);

  always_comb begin
    if (fin_ext > O_HI)      res_o = O_HI[23:0];
    else if (fin_ext < O_LO) res_o = O_LO[23:0];
    else                     res_o = fin_ext[23:0];
  end

endmodule

[rtl/gfm_dpath.sv]
// Datapath: configuration registers, grid coordinate unit, node checks,
// seen-mark and field memories, record count and three component lanes.
// Depends on gfm_pkg and gfm_lane.
module gfm_dpath #(
  parameter int unsigned AXIS_BITS   = 6,
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned FIELD_BITS  = 24,
  parameter int unsigned ON_GRID_TOL = 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [gfm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [gfm_pkg::CFG_W-1:0]       cfg_wdata_i,
  input  logic                            in_load_i,
  input  gfm_pkg::gfm_in_t                in_data_i,
  input  gfm_pkg::gfm_cmd_t               cmd_i,
  output gfm_pkg::gfm_sts_t               sts_o,
  output logic signed [23:0]              field_x_o,
  output logic signed [23:0]              field_y_o,
  output logic signed [23:0]              field_z_o
);
  import gfm_pkg::*;

  localparam int unsigned NODE_W = 3 * AXIS_BITS;
  localparam int unsigned NODES  = 1 << NODE_W;
  localparam int unsigned CNT_W  = AXIS_BITS + 1;
  localparam int unsigned STEP_SH = 32 - FRAC_BITS;
  localparam int unsigned GW     = FRAC_BITS + 34;
  localparam int unsigned KW     = GW - FRAC_BITS;
  localparam logic [64:0] HALF_STEP = 65'd1 << (STEP_SH - 1);
  localparam logic [GW-1:0] HALF_CELL = GW'(1) << (FRAC_BITS - 1);
  localparam logic [GW-1:0] TOL = GW'(ON_GRID_TOL);
  localparam logic [8:0] MAX_CNT = 9'(1 << AXIS_BITS);
  localparam int unsigned FW = 3 * FIELD_BITS;

  // configuration
  logic signed [31:0]  org_q [3];
  logic [31:0]         inv_q [3];
  logic [GRID_W-1:0]   grid_q;
  logic [SCALE_W-1:0]  scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_q[0] <= '0;
      org_q[1] <= '0;
      org_q[2] <= '0;
      inv_q[0] <= RST_INV;
      inv_q[1] <= RST_INV;
      inv_q[2] <= RST_INV;
      grid_q   <= RST_GRID;
      scale_q  <= RST_SCALE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ORIGIN_X: org_q[0] <= cfg_wdata_i;
        CFG_ORIGIN_Y: org_q[1] <= cfg_wdata_i;
        CFG_ORIGIN_Z: org_q[2] <= cfg_wdata_i;
        CFG_INV_X:    inv_q[0] <= cfg_wdata_i;
        CFG_INV_Y:    inv_q[1] <= cfg_wdata_i;
        CFG_INV_Z:    inv_q[2] <= cfg_wdata_i;
        CFG_GRID:     grid_q   <= cfg_wdata_i[GRID_W-1:0];
        CFG_SCALE:    scale_q  <= cfg_wdata_i[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  gfm_in_t in_q;
  always_ff @(posedge clk_i) begin
    if (in_load_i) in_q <= in_data_i;
  end

  // coordinate unit: one 32x32 multiplier shared by the axes
  logic signed [31:0] pos_sel, org_sel;
  logic [31:0]        inv_sel;
  logic signed [32:0] d_w;
  logic [32:0]        mag_w;
  logic [63:0]        mul_w, p_q;
  logic               neg_q;
  logic [64:0]        sum_w;
  logic [GW-2:0]      gm_w;
  logic signed [GW-1:0] g_w;
  logic signed [GW-1:0] g_q [3];

  always_comb begin
    case (cmd_i.axis)
      AX_X: begin
        pos_sel = in_q.pos_x;
        org_sel = org_q[0];
        inv_sel = inv_q[0];
      end
      AX_Y: begin
        pos_sel = in_q.pos_y;
        org_sel = org_q[1];
        inv_sel = inv_q[1];
      end
      default: begin
        pos_sel = in_q.pos_z;
        org_sel = org_q[2];
        inv_sel = inv_q[2];
      end
    endcase
  end

  assign d_w   = 33'(pos_sel) - 33'(org_sel);
  assign mag_w = d_w[32] ? 33'(-d_w) : 33'(d_w);
  assign mul_w = mag_w[31:0] * inv_sel;
  // negative side rounds half toward zero in magnitude
  assign sum_w = {1'b0, p_q} + (neg_q ? (HALF_STEP - 65'd1) : HALF_STEP);
  assign gm_w  = sum_w[64:STEP_SH];
  assign g_w   = neg_q ? -$signed({1'b0, gm_w}) : $signed({1'b0, gm_w});

  always_ff @(posedge clk_i) begin
    if (cmd_i.coord_mul) begin
      p_q   <= mag_w[32] ? {inv_sel, 32'd0} : mul_w;
      neg_q <= d_w[32];
    end
    if (cmd_i.coord_rnd) begin
      case (cmd_i.axis)
        AX_X:    g_q[0] <= g_w;
        AX_Y:    g_q[1] <= g_w;
        default: g_q[2] <= g_w;
      endcase
    end
  end

  // per axis node snapping and interpolation weights
  logic [23:0]           gc24;
  logic [CNT_W-1:0]      cnt [3];
  logic                  node_ok [3];
  logic                  q_ok [3];
  logic [AXIS_BITS-1:0]  node_w [3];
  logic [AXIS_BITS-1:0]  i0_w [3], i1_w [3];
  logic [FRAC_BITS-1:0]  w_w [3];
  logic [AXIS_BITS-1:0]  node_q [3];
  logic [AXIS_BITS-1:0]  i0_q [3], i1_q [3];
  logic [FRAC_BITS-1:0]  w_q [3];
  logic                  load_ok_q, query_ok_q;

  assign gc24 = {1'b0, grid_q};

  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic [8:0]       c9;
    logic [CNT_W-1:0] cm1;
    logic [GW-1:0]    gu, negmag, gplus, dposu, dev, last;
    logic [KW-1:0]    kw;
    logic             neg, off;

    assign c9  = {1'b0, gc24[8*a +: 8]};
    assign cnt[a] = (c9 < 9'd2) ? CNT_W'(2) : (c9 > MAX_CNT) ? CNT_W'(MAX_CNT) : CNT_W'(c9);
    assign cm1 = cnt[a] - CNT_W'(1);

    assign gu     = g_q[a];
    assign neg    = gu[GW-1];
    assign negmag = -gu;
    assign gplus  = gu + HALF_CELL;
    assign kw     = gplus[GW-1:FRAC_BITS];
    assign dposu  = gu - {kw, {FRAC_BITS{1'b0}}};
    assign dev    = neg ? negmag : (dposu[GW-1] ? -dposu : dposu);
    assign off    = neg ? (negmag > HALF_CELL) : (kw >= KW'(cnt[a]));
    assign node_ok[a] = !off && (dev <= TOL);
    assign node_w[a]  = neg ? '0 : kw[AXIS_BITS-1:0];

    assign last    = GW'({cm1, {FRAC_BITS{1'b0}}});
    assign q_ok[a] = !neg && (gu <= last);
    assign i0_w[a] = (gu == last) ? cm1[AXIS_BITS-1:0] : gu[FRAC_BITS +: AXIS_BITS];
    assign i1_w[a] = (gu == last) ? cm1[AXIS_BITS-1:0]
                                  : gu[FRAC_BITS +: AXIS_BITS] + AXIS_BITS'(1);
    assign w_w[a]  = (gu == last) ? '0 : gu[FRAC_BITS-1:0];

    always_ff @(posedge clk_i) begin
      if (cmd_i.classify) begin
        node_q[a] <= node_w[a];
        i0_q[a]   <= i0_w[a];
        i1_q[a]   <= i1_w[a];
        w_q[a]    <= w_w[a];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.classify) begin
      load_ok_q  <= node_ok[0] && node_ok[1] && node_ok[2];
      query_ok_q <= q_ok[0] && q_ok[1] && q_ok[2];
    end
  end

  // node count product, two registered multiplies
  logic [2*CNT_W-1:0] cnt_xy_q;
  logic [3*CNT_W-1:0] total_q;
  always_ff @(posedge clk_i) begin
    cnt_xy_q <= cnt[0] * cnt[1];
    total_q  <= cnt_xy_q * cnt[2];
  end

  logic [NODE_W-1:0] ld_addr;
  logic [NODE_W-1:0] rd_addr;
  assign ld_addr = {node_q[0], node_q[1], node_q[2]};
  assign rd_addr = {cmd_i.node_idx[2] ? i1_q[0] : i0_q[0],
                    cmd_i.node_idx[1] ? i1_q[1] : i0_q[1],
                    cmd_i.node_idx[0] ? i1_q[2] : i0_q[2]};

  // record count and clearing sweep
  logic [NODE_W:0]   rec_q;
  logic [NODE_W-1:0] sweep_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q   <= '0;
      sweep_q <= '0;
    end else begin
      if (cmd_i.rec_clr)       rec_q <= '0;
      else if (cmd_i.store_wr) rec_q <= rec_q + (NODE_W+1)'(1);
      if (cmd_i.sweep_step)    sweep_q <= sweep_q + NODE_W'(1);
    end
  end

  // seen marks
  logic seen_mem [NODES];
  logic seen_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep_step)    seen_mem[sweep_q] <= 1'b0;
    else if (cmd_i.store_wr) seen_mem[ld_addr] <= 1'b1;
    if (cmd_i.seen_rd)       seen_q <= seen_mem[ld_addr];
  end

  // field store, one word holds all three components
  logic signed [FIELD_BITS-1:0] st_w [3];
  logic [FW-1:0] fld_mem [NODES];
  logic [FW-1:0] fld_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.store_wr) fld_mem[ld_addr] <= {st_w[2], st_w[1], st_w[0]};
    if (cmd_i.node_rd)  fld_q <= fld_mem[rd_addr];
  end

  assign sts_o.sweep_last = (sweep_q == {NODE_W{1'b1}});
  assign sts_o.load_ok    = load_ok_q;
  assign sts_o.query_ok   = query_ok_q;
  assign sts_o.seen       = seen_q;
  assign sts_o.count_full = ((3*CNT_W)'(rec_q) == total_q);

  logic signed [23:0] raw_w [3];
  logic signed [23:0] res_w [3];
  assign raw_w[0] = in_q.raw_field_x;
  assign raw_w[1] = in_q.raw_field_y;
  assign raw_w[2] = in_q.raw_field_z;

  for (genvar c = 0; c < 3; c++) begin : g_lane
    gfm_lane #(
      .FRAC_BITS  (FRAC_BITS),
      .FIELD_BITS (FIELD_BITS)
    ) u_lane (
      .clk_i       (clk_i),
      .raw_i       (raw_w[c]),
      .scale_i     (scale_q),
      .store_o     (st_w[c]),
      .node_i      ($signed(fld_q[c*FIELD_BITS +: FIELD_BITS])),
      .node_push_i (cmd_i.node_push),
      .lerp_mul_i  (cmd_i.lerp_mul),
      .lerp_rnd_i  (cmd_i.lerp_rnd),
      .level_i     (cmd_i.level),
      .wz_i        (w_q[2]),
      .wy_i        (w_q[1]),
      .wx_i        (w_q[0]),
      .res_o       (res_w[c])
    );
  end

  assign field_x_o = res_w[0];
  assign field_y_o = res_w[1];
  assign field_z_o = res_w[2];

endmodule

[rtl/gfm_ctrl.sv]
// Controller: sequences coordinate, clear, load, finish and query steps,
// holds map readiness and the latched load or finish error.
// Depends on gfm_pkg.
module gfm_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  gfm_pkg::gfm_mode_e    in_mode_i,
  output logic                  in_stall_o,
  input  logic                  out_free_i,
  input  gfm_pkg::gfm_sts_t     sts_i,
  output gfm_pkg::gfm_cmd_t     cmd_o,
  output logic                  out_load_o,
  output gfm_pkg::gfm_status_e  res_status_o,
  output logic                  res_ready_o,
  output logic                  res_field_en_o
);
  import gfm_pkg::*;

  gfm_state_e  state_q, state_d;
  gfm_mode_e   mode_q, mode_d;
  gfm_status_e err_q, err_d, res_q, res_d;
  logic [1:0]  axis_q, axis_d;
  logic [3:0]  ncnt_q, ncnt_d;
  logic [2:0]  step_q, step_d;
  logic        ready_q, ready_d, fen_q, fen_d, pend_q, pend_d;
  gfm_level_e  level_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SWEEP;
      mode_q  <= MODE_CLEAR;
      err_q   <= STS_OK;
      res_q   <= STS_OK;
      axis_q  <= AX_X;
      ncnt_q  <= '0;
      step_q  <= '0;
      ready_q <= 1'b0;
      fen_q   <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      err_q   <= err_d;
      res_q   <= res_d;
      axis_q  <= axis_d;
      ncnt_q  <= ncnt_d;
      step_q  <= step_d;
      ready_q <= ready_d;
      fen_q   <= fen_d;
      pend_q  <= pend_d;
    end
  end

  // four z blends, two y blends, one x blend
  assign level_w = (step_q < 3'd4) ? LVL_Z : (step_q < 3'd6) ? LVL_Y : LVL_X;

  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    err_d      = err_q;
    res_d      = res_q;
    axis_d     = axis_q;
    ncnt_d     = ncnt_q;
    step_d     = step_q;
    ready_d    = ready_q;
    fen_d      = fen_q;
    pend_d     = pend_q;
    cmd_o      = '0;
    cmd_o.axis = axis_q;
    cmd_o.level = level_w;
    cmd_o.node_idx = ncnt_q[2:0];
    out_load_o = 1'b0;

    unique case (state_q)
      ST_SWEEP: begin
        cmd_o.sweep_step = 1'b1;
        if (sts_i.sweep_last) state_d = pend_q ? ST_RESULT : ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          mode_d  = in_mode_i;
          axis_d  = AX_X;
          fen_d   = 1'b0;
          res_d   = STS_OK;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.coord_mul = 1'b1;
        state_d = ST_RND;
      end
      ST_RND: begin
        cmd_o.coord_rnd = 1'b1;
        if (axis_q == AX_Z) begin
          state_d = ST_CLASS;
        end else begin
          axis_d  = axis_q + 2'd1;
          state_d = ST_MUL;
        end
      end
      ST_CLASS: begin
        cmd_o.classify = 1'b1;
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_d = ST_RESULT;
        unique case (mode_q)
          MODE_CLEAR: begin
            ready_d = 1'b0;
            err_d   = STS_OK;
            cmd_o.rec_clr = 1'b1;
            pend_d  = 1'b1;
            state_d = ST_SWEEP;
          end
          MODE_LOAD: begin
            if (ready_q || err_q != STS_OK) begin
              res_d = STS_ABORTED;
            end else if (!sts_i.load_ok) begin
              res_d = STS_OFF_GRID;
              err_d = STS_OFF_GRID;
            end else begin
              state_d = ST_SEEN_RD;
            end
          end
          MODE_FINISH: begin
            if (!ready_q) begin
              if (err_q != STS_OK) begin
                res_d = err_q;
              end else if (!sts_i.count_full) begin
                res_d = STS_INCOMPLETE;
                err_d = STS_INCOMPLETE;
              end else begin
                ready_d = 1'b1;
              end
            end
          end
          MODE_QUERY: begin
            if (!ready_q) begin
              res_d = STS_NOT_READY;
            end else if (!sts_i.query_ok) begin
              res_d = STS_RANGE;
            end else begin
              ncnt_d  = '0;
              state_d = ST_NODE_RD;
            end
          end
          default: ;
        endcase
      end
      ST_SEEN_RD: begin
        cmd_o.seen_rd = 1'b1;
        state_d = ST_SEEN_CHK;
      end
      ST_SEEN_CHK: begin
        if (sts_i.seen) begin
          res_d = STS_DUP;
          err_d = STS_DUP;
        end else begin
          cmd_o.store_wr = 1'b1;
        end
        state_d = ST_RESULT;
      end
      ST_NODE_RD: begin
        // read data lands in the cycle after each address
        cmd_o.node_rd   = !ncnt_q[3];
        cmd_o.node_push = (ncnt_q != 4'd0);
        if (ncnt_q[3]) begin
          step_d  = '0;
          state_d = ST_LERP_MUL;
        end else begin
          ncnt_d = ncnt_q + 4'd1;
        end
      end
      ST_LERP_MUL: begin
        cmd_o.lerp_mul = 1'b1;
        state_d = ST_LERP_RND;
      end
      ST_LERP_RND: begin
        cmd_o.lerp_rnd = 1'b1;
        if (step_q == 3'd6) begin
          fen_d   = 1'b1;
          state_d = ST_RESULT;
        end else begin
          step_d  = step_q + 3'd1;
          state_d = ST_LERP_MUL;
        end
      end
      ST_RESULT: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          pend_d     = 1'b0;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign res_status_o   = res_q;
  assign res_ready_o    = ready_q;
  assign res_field_en_o = fen_q;

endmodule

[rtl/grid_field_map_trilinear.sv]
// Grid field map with trilinear lookup. One item at a time.
// A query makes eight single-port node reads and seven blend steps per lane.
// Clear runs the seen-mark sweep over all 2^(3*AXIS_BITS) nodes.
// After reset the same sweep runs before the first item is taken.
// Depends on gfm_pkg, gfm_ctrl and gfm_dpath.
module grid_field_map_trilinear #(
  parameter int unsigned AXIS_BITS   = 6,
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned FIELD_BITS  = 24,
  parameter int unsigned ON_GRID_TOL = 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [gfm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [gfm_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  gfm_pkg::gfm_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output gfm_pkg::gfm_out_t              out_data_o
);
  import gfm_pkg::*;

  gfm_cmd_t    cmd;
  gfm_sts_t    sts;
  gfm_status_e res_status;
  logic        res_ready, res_fen, out_load, out_free, in_acc;
  logic signed [23:0] fx, fy, fz;
  logic        out_valid_q;
  gfm_out_t    out_q;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  gfm_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_mode_i      (in_data_i.mode),
    .in_stall_o     (in_stall_o),
    .out_free_i     (out_free),
    .sts_i          (sts),
    .cmd_o          (cmd),
    .out_load_o     (out_load),
    .res_status_o   (res_status),
    .res_ready_o    (res_ready),
    .res_field_en_o (res_fen)
  );

  gfm_dpath #(
    .AXIS_BITS   (AXIS_BITS),
    .FRAC_BITS   (FRAC_BITS),
    .FIELD_BITS  (FIELD_BITS),
    .ON_GRID_TOL (ON_GRID_TOL)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_load_i   (in_acc),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .field_x_o   (fx),
    .field_y_o   (fy),
    .field_z_o   (fz)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.status    <= res_status;
      out_q.ready_res <= res_ready;
      out_q.field_x   <= res_fen ? fx : '0;
      out_q.field_y   <= res_fen ? fy : '0;
      out_q.field_z   <= res_fen ? fz : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // one item in flight: an accepted item closes the input side
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while an item is in flight");

  // only a successful query carries a field
  a_zero_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != STS_OK |->
      out_data_o.field_x == '0 && out_data_o.field_y == '0 && out_data_o.field_z == '0)
    else $error("field on a failed item");

  a_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == STS_NOT_READY |-> !out_data_o.ready_res)
    else $error("not-ready status with map ready");

endmodule
